### rtl/c2e_pkg.sv
// ----------------------------------------------------------------------------
// c2e_pkg
// Shared types, constants and tables for the calendar to epoch converter.
// ----------------------------------------------------------------------------
package c2e_pkg;

   // Field widths of one request and one response beat.
   localparam int YearW   = 14;
   localparam int MonthW  = 4;
   localparam int DayW    = 5;
   localparam int HourW   = 5;
   localparam int MinuteW = 6;
   localparam int SecondW = 6;
   localparam int EpochW  = 39;

   // Internal widths: day count, scaled seconds, time of day and days before month.
   localparam int DaysW = 23;
   localparam int ProdW = 41;
   localparam int TodW  = 17;
   localparam int DbmW  = 9;

   // Year and month clamp limits.
   localparam logic [YearW-1:0] YearMin = 14'd1;
   localparam logic [YearW-1:0] YearMax = 14'd9999;
   localparam logic [MonthW-1:0] MonthMin = 4'd1;
   localparam logic [MonthW-1:0] MonthMax = 4'd12;

   // Four hundred year cycle, the offset from year one to the epoch and seconds per unit.
   localparam logic [YearW-1:0]      YearsPerCycle = 14'd400;
   localparam logic signed [DaysW-1:0] DaysPerCycle = 23'sd146097;
   localparam logic signed [ProdW-1:0] YearOneToEpoch = 41'sd62135596800;
   localparam logic signed [17:0]    SecsPerDay = 18'sd86400;
   localparam logic [11:0]           SecsPerHour = 12'd3600;
   localparam logic [5:0]            SecsPerMinute = 6'd60;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic reduce;
      logic days;
      logic scale;
      logic finish;
   } c2e_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cycle_left;
   } c2e_status_type;

   // Days that come before the first day of each month in a common year.
   function automatic logic [DbmW-1:0] days_before_month(input logic [MonthW-1:0] month);
      logic [DbmW-1:0] d;
      case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

### rtl/c2e_datapath.sv
// ----------------------------------------------------------------------------
// c2e_datapath
// Holds the request fields, strips whole 400-year cycles one per cycle,
// adds the remaining days, scales to seconds and builds the response.
// ----------------------------------------------------------------------------
module c2e_datapath (
   input  logic                             clock,
   input  c2e_pkg::c2e_cmd_type             cmd,
   output c2e_pkg::c2e_status_type          status,
   input  logic [c2e_pkg::YearW-1:0]        req_cal_year,
   input  logic [c2e_pkg::MonthW-1:0]       req_cal_month,
   input  logic [c2e_pkg::DayW-1:0]         req_cal_day,
   input  logic [c2e_pkg::HourW-1:0]        req_cal_hour,
   input  logic [c2e_pkg::MinuteW-1:0]      req_cal_minute,
   input  logic [c2e_pkg::SecondW-1:0]      req_cal_second,
   output logic signed [c2e_pkg::EpochW-1:0] rsp_epoch_seconds
);
   import c2e_pkg::*;

   logic [YearW-1:0]          rem_ff, rem_in;
   logic [MonthW-1:0]         month_ff, month_in;
   logic [DayW-1:0]           day_ff;
   logic [HourW-1:0]          hour_ff;
   logic [MinuteW-1:0]        minute_ff;
   logic [SecondW-1:0]        second_ff;
   logic signed [DaysW-1:0]   days_ff, days_in;
   logic signed [ProdW-1:0]   prod_ff;
   logic [TodW-1:0]           tod_ff;
   logic signed [EpochW-1:0]  epoch_ff;

   logic [YearW-1:0]          year_clamped;
   logic [8:0]                rem_short;
   logic [1:0]                rem_div100;
   logic                      leap;
   logic signed [DaysW-1:0]   days_rest;
   logic signed [ProdW-1:0]   prod_in;
   logic [TodW-1:0]           tod_in;
   logic signed [ProdW-1:0]   sum_in;

   // Year and month clamps at the request beat.
   always_comb begin
      year_clamped = req_cal_year;
      if (req_cal_year < YearMin) begin
         year_clamped = YearMin;
      end else if (req_cal_year > YearMax) begin
         year_clamped = YearMax;
      end
      month_in = req_cal_month;
      if (req_cal_month < MonthMin) begin
         month_in = MonthMin;
      end else if (req_cal_month > MonthMax) begin
         month_in = MonthMax;
      end
   end

   // A whole cycle remains while the years left reach four hundred.
   assign status.cycle_left = (rem_ff >= YearsPerCycle);

   // Years left within the cycle are below 400 once reduction ends.
   assign rem_short = rem_ff[8:0];

   always_comb begin
      if (rem_short >= 9'd300) begin
         rem_div100 = 2'd3;
      end else if (rem_short >= 9'd200) begin
         rem_div100 = 2'd2;
      end else if (rem_short >= 9'd100) begin
         rem_div100 = 2'd1;
      end else begin
         rem_div100 = 2'd0;
      end
   end

   // The year is a leap year when it is a multiple of four, except for
   // century years that are not a multiple of four hundred.
   assign leap = (rem_short[1:0] == 2'b11) && (rem_short != 9'd99)
                 && (rem_short != 9'd199) && (rem_short != 9'd299);

   // Days from the start of the cycle to the requested day.
   always_comb begin
      days_rest = $signed({14'd0, rem_short}) * 23'sd365
                + $signed({16'd0, rem_short[8:2]})
                - $signed({21'd0, rem_div100})
                + $signed({14'd0, days_before_month(month_ff)})
                + $signed({18'd0, day_ff})
                - 23'sd1;
      if (leap && (month_ff > 4'd2)) begin
         days_rest = days_rest + 23'sd1;
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      days_in = days_ff;
      if (cmd.load) begin
         rem_in  = year_clamped - 14'd1;
         days_in = '0;
      end else if (cmd.reduce) begin
         rem_in  = rem_ff - YearsPerCycle;
         days_in = days_ff + DaysPerCycle;
      end else if (cmd.days) begin
         days_in = days_ff + days_rest;
      end
   end

   // Scale the day count and gather the time of day.
   assign prod_in = ProdW'(days_ff) * ProdW'(SecsPerDay);
   assign tod_in  = TodW'(hour_ff) * TodW'(SecsPerHour)
                  + TodW'(minute_ff) * TodW'(SecsPerMinute)
                  + TodW'(second_ff);
   assign sum_in  = prod_ff + $signed({24'd0, tod_ff}) - YearOneToEpoch;

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      days_ff <= days_in;
      if (cmd.load) begin
         month_ff  <= month_in;
         day_ff    <= req_cal_day;
         hour_ff   <= req_cal_hour;
         minute_ff <= req_cal_minute;
         second_ff <= req_cal_second;
      end
      if (cmd.scale) begin
         prod_ff <= prod_in;
         tod_ff  <= tod_in;
      end
      if (cmd.finish) begin
         epoch_ff <= sum_in[EpochW-1:0];
      end
   end

   assign rsp_epoch_seconds = epoch_ff;

endmodule

### rtl/c2e_controller.sv
// ----------------------------------------------------------------------------
// c2e_controller
// Sequences one conversion and owns both handshakes.
// ----------------------------------------------------------------------------
module c2e_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output c2e_pkg::c2e_cmd_type    cmd,
   input  c2e_pkg::c2e_status_type status
);
   import c2e_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      REDUCE,
      DAYS,
      SCALE,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff, req_stall_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && !req_stall_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Command decode from the current state.
   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == IDLE) && accept;
      cmd.reduce = (state_ff == REDUCE) && status.cycle_left;
      cmd.days   = (state_ff == DAYS);
      cmd.scale  = (state_ff == SCALE);
      cmd.finish = (state_ff == FINISH) && out_free;
   end

   // Next state, stall and response valid.
   always_comb begin
      state_in     = state_ff;
      req_stall_in = req_stall_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         IDLE: begin
            if (accept) begin
               state_in     = REDUCE;
               req_stall_in = 1'b1;
            end
         end
         REDUCE: begin
            if (!status.cycle_left) begin
               state_in = DAYS;
            end
         end
         DAYS:  state_in = SCALE;
         SCALE: state_in = FINISH;
         FINISH: begin
            if (out_free) begin
               state_in     = IDLE;
               req_stall_in = 1'b0;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/calendar_to_epoch_seconds.sv
// From the request beat, REDUCE strips each whole 400-year cycle in (year - 1), then
// DAYS, SCALE and FINISH run before response valid; a stalled earlier response adds its stall.
// A new request is taken only once the last one has reached FINISH and been handed on.
// A finished beat waits in the response register while the next
// request is taken. Reset (synchronous, active high) clears the controller; no beat is
// pending after it.
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds
// Converts a proleptic Gregorian date and time to signed epoch seconds.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [c2e_pkg::YearW-1:0]         req_cal_year,
   input  logic [c2e_pkg::MonthW-1:0]        req_cal_month,
   input  logic [c2e_pkg::DayW-1:0]          req_cal_day,
   input  logic [c2e_pkg::HourW-1:0]         req_cal_hour,
   input  logic [c2e_pkg::MinuteW-1:0]       req_cal_minute,
   input  logic [c2e_pkg::SecondW-1:0]       req_cal_second,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [c2e_pkg::EpochW-1:0] rsp_epoch_seconds
);
   import c2e_pkg::*;

   c2e_cmd_type    cmd;
   c2e_status_type status;

   // Sequencer.
   c2e_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and response register.
   c2e_datapath u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .status            (status),
      .req_cal_year      (req_cal_year),
      .req_cal_month     (req_cal_month),
      .req_cal_day       (req_cal_day),
      .req_cal_hour      (req_cal_hour),
      .req_cal_minute    (req_cal_minute),
      .req_cal_second    (req_cal_second),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

endmodule

### tb/calendar_to_epoch_seconds_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds_tb
// Drives calendar dates and times into the converter and checks every
// response beat against a date arithmetic predictor held in the bench.
// Directed dates cover the range ends, the clamps, leap rules and fields
// that run past their range. Random dates follow with gaps and stalls on
// both channels, a stretch at full rate and a long receiver hold-off.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds_tb;
   import c2e_pkg::*;

   // One request beat, field by field.
   typedef struct packed {
      logic [YearW-1:0]   year;
      logic [MonthW-1:0]  month;
      logic [DayW-1:0]    day;
      logic [HourW-1:0]   hour;
      logic [MinuteW-1:0] minute;
      logic [SecondW-1:0] second;
   } cal_date_type;

   localparam int     DateW           = $bits(cal_date_type);
   localparam longint DaysPer400Years = 146097;
   localparam longint SecondsPerDay   = 86400;
   localparam longint YearOneOffset   = 64'd62135596800;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [YearW-1:0]         req_cal_year = '0;
   logic [MonthW-1:0]        req_cal_month = '0;
   logic [DayW-1:0]          req_cal_day = '0;
   logic [HourW-1:0]         req_cal_hour = '0;
   logic [MinuteW-1:0]       req_cal_minute = '0;
   logic [SecondW-1:0]       req_cal_second = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [EpochW-1:0] rsp_epoch_seconds;

   // Expected epoch seconds, oldest first.
   logic signed [EpochW-1:0] pending_epochs[$];
   int                       mismatch_count = 0;

   // Idling controls for the send task and the receiver stall process, set by the test tasks.
   bit sender_idles   = 1'b0;
   bit receiver_stalls = 1'b0;
   int hold_off_left  = 0;
   int stall_left     = 0;
   int stall_pick;

   calendar_to_epoch_seconds u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cal_year      (req_cal_year),
      .req_cal_month     (req_cal_month),
      .req_cal_day       (req_cal_day),
      .req_cal_hour      (req_cal_hour),
      .req_cal_minute    (req_cal_minute),
      .req_cal_second    (req_cal_second),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Proleptic Gregorian date and time to seconds since the epoch.
   function automatic logic signed [EpochW-1:0] epoch_of_date(input cal_date_type d);
      longint y, m, q, r, days, secs;
      y = longint'(d.year);
      m = longint'(d.month);
      if (y < 1) y = 1;
      if (y > 9999) y = 9999;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      // Whole 400-year cycles, then the years left, with the 4/100 rule.
      q = y - 1;
      r = q % 400;
      days = (q / 400) * DaysPer400Years + r * 365 + r / 4 - r / 100;
      // Month lengths of a common year up to the month in question.
      for (longint i = 1; i < m; i++) begin
         if (i == 2) days += 28;
         else if (i == 4 || i == 6 || i == 9 || i == 11) days += 30;
         else days += 31;
      end
      // The leap day only counts once February is over.
      if (m > 2 && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) days += 1;
      days += longint'(d.day) - 1;
      secs = days * SecondsPerDay + longint'(d.hour) * 3600
           + longint'(d.minute) * 60 + longint'(d.second) - YearOneOffset;
      return secs[EpochW-1:0];
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Plausible dates with years spread over the range, plus some raw noise.
   function automatic cal_date_type random_date();
      cal_date_type d;
      int           p, y;
      p = $urandom_range(0, 99);
      if (p < 15) begin
         d = DateW'({$urandom, $urandom});
         return d;
      end
      case ($urandom_range(0, 9)) inside
         [0:4]:   y = $urandom_range(1, 9999);
         [5:6]:   y = $urandom_range(1900, 2100);
         [7:8]:   y = $urandom_range(0, 100) * 100 + $urandom_range(0, 2) - 1;
         default: y = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 400)
                                                  : $urandom_range(9600, 9999);
      endcase
      if (y < 1) y = 1;
      if (y > 9999) y = 9999;
      d.year   = y[YearW-1:0];
      d.month  = MonthW'($urandom_range(1, 12));
      d.day    = DayW'($urandom_range(1, 31));
      d.hour   = HourW'($urandom_range(0, 23));
      d.minute = MinuteW'($urandom_range(0, 59));
      d.second = SecondW'($urandom_range(0, 59));
      return d;
   endfunction

   // Offer one date and hold it until the block takes it.
   task automatic send_date(input cal_date_type d);
      int gap;
      req_valid      <= 1'b1;
      req_cal_year   <= d.year;
      req_cal_month  <= d.month;
      req_cal_day    <= d.day;
      req_cal_hour   <= d.hour;
      req_cal_minute <= d.minute;
      req_cal_second <= d.second;
      do @(posedge clock); while (req_stall);
      gap = sender_idles ? idle_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(input int y, input int mo, input int d, input int h,
                              input int mi, input int s);
      send_date({YearW'(y), MonthW'(mo), DayW'(d), HourW'(h), MinuteW'(mi),
                 SecondW'(s)});
   endtask

   // Range ends, clamps, leap rules and fields beyond their range.
   task automatic test_directed_dates();
      send_fields(1970, 1, 1, 0, 0, 0);
      send_fields(1969, 12, 31, 23, 59, 59);
      send_fields(1, 1, 1, 0, 0, 0);
      send_fields(9999, 12, 31, 23, 59, 59);
      send_fields(0, 1, 1, 0, 0, 0);
      send_fields(10000, 6, 15, 12, 0, 0);
      send_fields(16383, 15, 31, 31, 63, 63);
      send_fields(2021, 0, 10, 8, 30, 0);
      send_fields(2021, 13, 10, 8, 30, 0);
      send_fields(2021, 15, 10, 8, 30, 0);
      send_fields(2000, 2, 29, 12, 0, 0);
      send_fields(2000, 3, 1, 0, 0, 0);
      send_fields(1900, 3, 1, 0, 0, 0);
      send_fields(2024, 3, 1, 0, 0, 0);
      send_fields(2023, 3, 1, 0, 0, 0);
      send_fields(2023, 3, 0, 0, 0, 0);
      send_fields(2023, 2, 30, 0, 0, 0);
      send_fields(2023, 2, 0, 0, 0, 0);
      send_fields(2038, 1, 19, 3, 14, 8);
      send_fields(1999, 12, 31, 24, 0, 0);
      send_fields(1600, 1, 1, 0, 63, 63);
      send_fields(400, 12, 31, 0, 0, 0);
      send_fields(8191, 10, 21, 21, 42, 21);
   endtask

   // Random dates with gaps and stalls on both channels.
   task automatic test_random_dates(input int count);
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      repeat (count) send_date(random_date());
   endtask

   // A stretch with no idling on either side.
   task automatic test_full_rate(input int count);
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      repeat (count) send_date(random_date());
   endtask

   // The receiver holds off for a long time while dates keep coming.
   task automatic test_back_pressure(input int count);
      sender_idles    = 1'b0;
      receiver_stalls = 1'b1;
      hold_off_left   = 300;
      repeat (count) send_date(random_date());
   endtask

   // Receiver stall pattern: a counted hold-off first, then random stalls.
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else if (!receiver_stalls) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 60) begin
            rsp_stall <= 1'b0;
         end else if (stall_pick < 95) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(10, 40);
         end
      end
   end

   // Predict each accepted request beat and check each accepted response beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_epochs.size() == 0) begin
            $error("epoch_seconds: unexpected beat, got %0d", rsp_epoch_seconds);
            mismatch_count++;
         end else if (rsp_epoch_seconds !== pending_epochs[0]) begin
            $error("epoch_seconds: expected %0d, got %0d", pending_epochs[0],
                   rsp_epoch_seconds);
            mismatch_count++;
            void'(pending_epochs.pop_front());
         end else begin
            void'(pending_epochs.pop_front());
         end
      end
      if (!reset && req_valid && !req_stall) begin
         pending_epochs.push_back(epoch_of_date({req_cal_year, req_cal_month,
            req_cal_day, req_cal_hour, req_cal_minute, req_cal_second}));
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_dates();
      test_random_dates(350);
      test_full_rate(100);
      test_back_pressure(100);
      test_random_dates(60);
      // Drain the response channel.
      req_valid       <= 1'b0;
      receiver_stalls = 1'b0;
      while (pending_epochs.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_epochs.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### filelist.f
rtl/c2e_pkg.sv
rtl/c2e_datapath.sv
rtl/c2e_controller.sv
rtl/calendar_to_epoch_seconds.sv
tb/calendar_to_epoch_seconds_tb.sv
